### sv/base_relocation_block_writer_top_assert.svh
// Assertion macros shared by the block's checker.
// No dependencies; take in by include inside a module body.
`ifndef BASE_RELOCATION_BLOCK_WRITER_TOP_ASSERT_SVH
`define BASE_RELOCATION_BLOCK_WRITER_TOP_ASSERT_SVH

// Clocked assertion, quiet while reset is high.
`define BRBW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define BRBW_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### sv/brbw_pkg.sv
// Package for the base relocation block writer: record kinds, commands,
// byte counts and the record types passed between the framer and drain.
package brbw_pkg;

   localparam int PAGE_BITS_DEF = 12;
   localparam int MAX_RECS      = 4;
   localparam int REC_IDX_W     = $clog2(MAX_RECS);

   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_CLOSE = 1'b1;

   localparam logic [2:0] KIND_HEADER = 3'd0;
   localparam logic [2:0] KIND_ENTRY  = 3'd1;
   localparam logic [2:0] KIND_FILLER = 3'd2;
   localparam logic [2:0] KIND_SIZE   = 3'd3;
   localparam logic [2:0] KIND_END    = 3'd4;

   localparam logic [31:0] RELOC_HIGHLOW = 32'd3;
   localparam logic [31:0] HEADER_BYTES  = 32'd8;
   localparam logic [31:0] ENTRY_BYTES   = 32'd2;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] value;
      logic [31:0] patch_offset;
   } rec_type;

   // All records caused by one input word, in output order.
   typedef struct packed {
      rec_type [MAX_RECS-1:0] recs;
      logic [REC_IDX_W-1:0]   last_idx;
   } rec_set_type;

endpackage

### sv/brbw_if.sv
// Handshake channels of the base relocation block writer.
// Depends on nothing; payload widths are fixed by the record format.
interface brbw_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [31:0] address;

   modport source (output valid, command, address, input ready);
   modport sink   (input valid, command, address, output ready);
endinterface

interface brbw_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [31:0] value;
   logic [31:0] patch_offset;
   logic        last;

   modport source (output valid, kind, value, patch_offset, last, input ready);
   modport sink   (input valid, kind, value, patch_offset, last, output ready);
endinterface

### sv/brbw_framer.sv
// Framer: holds the block state and turns each accepted word into its
// record set, registered. Depends on brbw_pkg and brbw_req_if.
module brbw_framer #(
   parameter int PAGE_BITS = brbw_pkg::PAGE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   brbw_req_if.sink              req_bus,
   output logic                  set_valid,
   output brbw_pkg::rec_set_type set_out,
   input  logic                  set_take
);
   import brbw_pkg::*;

   localparam int PAGE_W = 32 - PAGE_BITS;

   logic [PAGE_W-1:0] page_base_ff, page_base_in;
   logic              page_open_ff, page_open_in;
   logic [31:0]       header_offset_ff, header_offset_in;
   logic [31:0]       bytes_written_ff, bytes_written_in;
   logic              set_valid_ff;
   rec_set_type       set_ff, set_in;

   logic [PAGE_W-1:0]    page;
   logic [PAGE_BITS-1:0] off;
   logic [31:0]          blk_len, pad_bytes, bw_pad, len_pad;
   logic                 do_close, do_open, pad;
   logic [REC_IDX_W:0]   n;
   logic                 accept;

   assign req_bus.ready = !set_valid_ff || set_take;
   assign accept        = req_bus.valid && req_bus.ready;
   assign set_valid     = set_valid_ff;
   assign set_out       = set_ff;

   always_comb begin
      page      = req_bus.address[31:PAGE_BITS];
      off       = req_bus.address[PAGE_BITS-1:0];
      blk_len   = bytes_written_ff - header_offset_ff;
      do_close  = page_open_ff && (req_bus.command == CMD_CLOSE || page != page_base_ff);
      do_open   = req_bus.command == CMD_ADD && (!page_open_ff || page != page_base_ff);
      pad       = do_close && (blk_len[1:0] != 2'd0);
      pad_bytes = pad ? ENTRY_BYTES : 32'd0;
      bw_pad    = bytes_written_ff + pad_bytes;
      len_pad   = blk_len + pad_bytes;

      set_in = '0;
      n      = '0;
      page_base_in     = page_base_ff;
      page_open_in     = page_open_ff;
      header_offset_in = header_offset_ff;
      bytes_written_in = bytes_written_ff;

      if (pad) begin
         set_in.recs[n[REC_IDX_W-1:0]] = '{KIND_FILLER, 32'd0, 32'd0};
         n = n + 1'b1;
      end
      if (do_close) begin
         set_in.recs[n[REC_IDX_W-1:0]] = '{KIND_SIZE, len_pad, header_offset_ff};
         n = n + 1'b1;
      end
      if (req_bus.command == CMD_ADD) begin
         if (do_open) begin
            set_in.recs[n[REC_IDX_W-1:0]] =
               '{KIND_HEADER, {page, {PAGE_BITS{1'b0}}}, 32'd0};
            n = n + 1'b1;
            page_base_in     = page;
            header_offset_in = bw_pad;
         end
         set_in.recs[n[REC_IDX_W-1:0]] =
            '{KIND_ENTRY, (RELOC_HIGHLOW << PAGE_BITS) | 32'(off), 32'd0};
         n = n + 1'b1;
         page_open_in     = 1'b1;
         // header plus entry in one add when a block opens
         bytes_written_in = bw_pad + (do_open ? HEADER_BYTES + ENTRY_BYTES : ENTRY_BYTES);
      end else begin
         set_in.recs[n[REC_IDX_W-1:0]] = '{KIND_END, bw_pad, 32'd0};
         n = n + 1'b1;
         page_base_in     = '0;
         page_open_in     = 1'b0;
         header_offset_in = '0;
         bytes_written_in = '0;
      end
      set_in.last_idx = REC_IDX_W'(n - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_base_ff     <= '0;
         page_open_ff     <= 1'b0;
         header_offset_ff <= '0;
         bytes_written_ff <= '0;
         set_valid_ff     <= 1'b0;
      end else begin
         if (accept) begin
            page_base_ff     <= page_base_in;
            page_open_ff     <= page_open_in;
            header_offset_ff <= header_offset_in;
            bytes_written_ff <= bytes_written_in;
            set_valid_ff     <= 1'b1;
         end else if (set_take) begin
            set_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         set_ff <= set_in;
      end
   end

endmodule

### sv/brbw_drain.sv
// Output stage: holds one record set and hands its records out one word
// per cycle while rsp_bus.ready is high. Depends on brbw_pkg and brbw_rsp_if.
module brbw_drain (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  set_valid,
   input  brbw_pkg::rec_set_type set_in,
   output logic                  set_take,
   brbw_rsp_if.source            rsp_bus
);
   import brbw_pkg::*;

   logic                 busy_ff;
   rec_set_type          cur_ff;
   logic [REC_IDX_W-1:0] idx_ff;
   logic                 fire, at_last;
   rec_type              rec;

   assign fire     = busy_ff && rsp_bus.ready;
   assign at_last  = idx_ff == cur_ff.last_idx;
   assign set_take = set_valid && (!busy_ff || (fire && at_last));

   assign rec                  = cur_ff.recs[idx_ff];
   assign rsp_bus.valid        = busy_ff;
   assign rsp_bus.kind         = rec.kind;
   assign rsp_bus.value        = rec.value;
   assign rsp_bus.patch_offset = rec.patch_offset;
   assign rsp_bus.last         = at_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         if (set_take) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (fire) begin
            if (at_last) begin
               busy_ff <= 1'b0;
               idx_ff  <= '0;
            end else begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (set_take) begin
         cur_ff <= set_in;
      end
   end

endmodule

### sv/base_relocation_block_writer_top.sv
// Base relocation block writer. Each accepted word (add address or close table) is
// turned into its records: filler when a closing block needs padding, size patch
// when a block closes, header when a page opens, then the entry, or the end record
// on close. Records pass the framer's and then the drain's set register and leave
// one per cycle in order while the output is ready, the final one flagged by last.
// An add within the open page gives one record, so such words flow at one per cycle
// while the output is ready; a word that gives more records holds the output until
// all have left. A new word is taken while an earlier one's records still drain.
module base_relocation_block_writer_top #(
   parameter int PAGE_BITS = brbw_pkg::PAGE_BITS_DEF
) (
   input logic          clock,
   input logic          reset,
   brbw_req_if.sink     req_bus,
   brbw_rsp_if.source   rsp_bus
);
   import brbw_pkg::*;

   logic        set_valid;
   logic        set_take;
   rec_set_type set_data;

   brbw_framer #(
      .PAGE_BITS (PAGE_BITS)
   ) u_framer (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .set_valid (set_valid),
      .set_out   (set_data),
      .set_take  (set_take)
   );

   brbw_drain u_drain (
      .clock     (clock),
      .reset     (reset),
      .set_valid (set_valid),
      .set_in    (set_data),
      .set_take  (set_take),
      .rsp_bus   (rsp_bus)
   );

endmodule

### sv/brbw_checker.sv
// Port-level checks on the base relocation block writer, bound to the top.
// Depends on brbw_pkg and the assertion macro header.
module brbw_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_kind,
   input logic [31:0] rsp_value,
   input logic        rsp_last
);
   import brbw_pkg::*;
   `include "base_relocation_block_writer_top_assert.svh"

   `BRBW_ASSERT_ALWAYS(a_idle_after_reset, reset |=> !rsp_valid, "output valid after reset")
   `BRBW_ASSERT(a_hold_stalled, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value), "stalled word changed")
   `BRBW_ASSERT(a_size_aligned, rsp_valid && rsp_kind == KIND_SIZE |-> rsp_value[1:0] == 2'd0, "block length not a multiple of 4")
   `BRBW_ASSERT(a_end_is_last, rsp_valid && rsp_kind == KIND_END |-> rsp_last, "end record not last")
   `BRBW_ASSERT(a_hdr_not_last, rsp_valid && (rsp_kind == KIND_HEADER || rsp_kind == KIND_FILLER) |-> !rsp_last, "header or filler marked last")

endmodule

bind base_relocation_block_writer_top brbw_checker u_brbw_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_kind  (rsp_bus.kind),
   .rsp_value (rsp_bus.value),
   .rsp_last  (rsp_bus.last)
);
